/* src/mhd_pkg.sv */
package mhd_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int QUO_BITS   = WORD_BITS + FRAC_BITS;
    localparam int DIV_STAGES = QUO_BITS;
    localparam int NUM_LANES  = 3;
    localparam int GM_BITS    = 21;
    localparam int IGM_BITS   = 25;
    localparam int ADDR_BITS  = 3;
    localparam int IDX_BIT    = 2;
    localparam int DATA_BITS  = 32;
    localparam int WIDE_BITS  = 2 * WORD_BITS;

    localparam logic [GM_BITS-1:0]  GM_RESET  = GM_BITS'(43691);
    localparam logic [IGM_BITS-1:0] IGM_RESET = IGM_BITS'(98304);

    // Register indexes as decoded from the address.
    localparam logic REG_GAMMA     = 1'b0;
    localparam logic REG_INV_GAMMA = 1'b1;

    // Operation codes.
    localparam logic OP_CONS_TO_PRIM = 1'b0;
    localparam logic OP_PRIM_TO_CONS = 1'b1;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [WIDE_BITS-1:0] wide_t;
    typedef logic [QUO_BITS-1:0] quo_t;
    typedef quo_t [NUM_LANES-1:0] quo_vec_t;

    localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam wide_t WMAX_W = {{(WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam wide_t WMIN_W = {{(WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
    localparam wide_t QHALF_W = wide_t'(64'd1 << (FRAC_BITS - 1));

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_DENSITY = 2'd1,
        STATUS_NONPOS  = 2'd2,
        STATUS_SAT     = 2'd3
    } status_t;

    typedef struct packed {
        logic  operation;
        word_t in_density;
        word_t in_x_comp;
        word_t in_y_comp;
        word_t in_z_comp;
        word_t in_energy_or_pressure;
        word_t in_field_x;
        word_t in_field_y;
        word_t in_field_z;
    } in_word_t;

    typedef struct packed {
        word_t   out_density;
        word_t   out_x_comp;
        word_t   out_y_comp;
        word_t   out_z_comp;
        word_t   out_energy_or_pressure;
        word_t   out_field_x;
        word_t   out_field_y;
        word_t   out_field_z;
        status_t status;
    } out_word_t;

    typedef struct packed {
        logic  clip;
        word_t val;
    } qres_t;

    function automatic word_t comp_of(input in_word_t w, input int unsigned lane);
        word_t r;
        case (lane)
            0: r = w.in_x_comp;
            1: r = w.in_y_comp;
            default: r = w.in_z_comp;
        endcase
        return r;
    endfunction

    function automatic word_t field_of(input in_word_t w, input int unsigned lane);
        word_t r;
        case (lane)
            0: r = w.in_field_x;
            1: r = w.in_field_y;
            default: r = w.in_field_z;
        endcase
        return r;
    endfunction

    function automatic qres_t sat_wide(input wide_t x);
        qres_t r;
        if (x > WMAX_W) begin
            r.clip = 1'b1;
            r.val  = WMAX;
        end else if (x < WMIN_W) begin
            r.clip = 1'b1;
            r.val  = WMIN;
        end else begin
            r.clip = 1'b0;
            r.val  = x[WORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic qres_t qadd(input word_t a, input word_t b);
        wide_t s;
        s = wide_t'(a) + wide_t'(b);
        return sat_wide(s);
    endfunction

    function automatic qres_t qsub(input word_t a, input word_t b);
        wide_t s;
        s = wide_t'(a) - wide_t'(b);
        return sat_wide(s);
    endfunction

    // Product rounded half up, then saturated.
    function automatic qres_t qmul(input word_t a, input word_t b);
        wide_t p;
        p = wide_t'(a) * wide_t'(b);
        p = p + QHALF_W;
        return sat_wide(p >>> FRAC_BITS);
    endfunction

    // Multiplication by one half in the same rounding; it never saturates.
    function automatic word_t qhalf(input word_t a);
        logic signed [WORD_BITS:0] t;
        t = {a[WORD_BITS-1], a} + (WORD_BITS+1)'(1);
        return t[WORD_BITS:1];
    endfunction

endpackage

/* src/mhd_cfg.sv */
module mhd_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mhd_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [mhd_pkg::DATA_BITS-1:0]  pwdata,
    output logic [mhd_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output logic [mhd_pkg::GM_BITS-1:0]    gamma_minus_one,
    output logic [mhd_pkg::IGM_BITS-1:0]   inv_gamma_minus_one
);

    logic [mhd_pkg::GM_BITS-1:0]  gamma_reg;
    logic [mhd_pkg::IGM_BITS-1:0] inv_gamma_reg;
    logic                         wr_en;
    logic                         idx;

    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[mhd_pkg::IDX_BIT];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg     <= mhd_pkg::GM_RESET;
            inv_gamma_reg <= mhd_pkg::IGM_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                mhd_pkg::REG_GAMMA:     gamma_reg     <= pwdata[mhd_pkg::GM_BITS-1:0];
                mhd_pkg::REG_INV_GAMMA: inv_gamma_reg <= pwdata[mhd_pkg::IGM_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            mhd_pkg::REG_GAMMA:
                prdata = {{(mhd_pkg::DATA_BITS-mhd_pkg::GM_BITS){1'b0}}, gamma_reg};
            mhd_pkg::REG_INV_GAMMA:
                prdata = {{(mhd_pkg::DATA_BITS-mhd_pkg::IGM_BITS){1'b0}}, inv_gamma_reg};
            default:
                prdata = '0;
        endcase
    end

    assign gamma_minus_one     = gamma_reg;
    assign inv_gamma_minus_one = inv_gamma_reg;

endmodule

/* src/mhd_div.sv */
module mhd_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  mhd_pkg::in_word_t  in_word,
    output logic               out_valid,
    output mhd_pkg::in_word_t  out_word,
    output mhd_pkg::quo_vec_t  quo
);

    // Restoring division of |momentum| * 2^F by density, one quotient bit
    // per stage. The dividend shifts out of the top of nq while quotient
    // bits shift in at the bottom.
    localparam int W  = mhd_pkg::WORD_BITS;
    localparam int QB = mhd_pkg::QUO_BITS;
    localparam int NS = mhd_pkg::DIV_STAGES;
    localparam int NL = mhd_pkg::NUM_LANES;

    logic [NS-1:0]      vld_reg;
    logic [NS-1:0]      vld_next;
    mhd_pkg::in_word_t  pay_reg  [NS];
    mhd_pkg::in_word_t  pay_next [NS];
    logic [W-1:0]       rem_reg  [NS][NL];
    logic [W-1:0]       rem_next [NS][NL];
    logic [QB-1:0]      nq_reg   [NS][NL];
    logic [QB-1:0]      nq_next  [NS][NL];

    always_comb
    begin
        mhd_pkg::in_word_t src_pay;
        logic [W-1:0]      src_rem;
        logic [QB-1:0]     src_nq;
        logic [W-1:0]      mag;
        logic [W-1:0]      dvs;
        logic [W:0]        r2;
        logic [W:0]        diff;
        logic              ge;
        mhd_pkg::word_t    m;
        for (int k = 0; k < NS; k++)
        begin
            if (k == 0)
            begin
                src_pay     = in_word;
                vld_next[k] = in_valid;
            end
            else
            begin
                src_pay     = pay_reg[k-1];
                vld_next[k] = vld_reg[k-1];
            end
            pay_next[k] = src_pay;
            dvs = src_pay.in_density;
            for (int l = 0; l < NL; l++)
            begin
                if (k == 0)
                begin
                    m       = mhd_pkg::comp_of(in_word, l);
                    mag     = m[W-1] ? (~m + W'(1)) : m;
                    src_rem = '0;
                    src_nq  = {mag, {mhd_pkg::FRAC_BITS{1'b0}}};
                end
                else
                begin
                    src_rem = rem_reg[k-1][l];
                    src_nq  = nq_reg[k-1][l];
                end
                r2   = {src_rem, src_nq[QB-1]};
                diff = r2 - {1'b0, dvs};
                ge   = (r2 >= {1'b0, dvs});
                rem_next[k][l] = ge ? diff[W-1:0] : r2[W-1:0];
                nq_next[k][l]  = {src_nq[QB-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            pay_reg[k] <= pay_next[k];
            for (int l = 0; l < NL; l++)
            begin
                rem_reg[k][l] <= rem_next[k][l];
                nq_reg[k][l]  <= nq_next[k][l];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_word  = pay_reg[NS-1];

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            quo[l] = nq_reg[NS-1][l];
        end
    end

endmodule

/* src/mhd_arith.sv */
module mhd_arith (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  mhd_pkg::in_word_t             in_word,
    input  mhd_pkg::quo_vec_t             quo,
    input  logic [mhd_pkg::GM_BITS-1:0]   gamma_minus_one,
    input  logic [mhd_pkg::IGM_BITS-1:0]  inv_gamma_minus_one,
    output logic                          out_valid,
    output mhd_pkg::out_word_t            out_word
);

    localparam int W  = mhd_pkg::WORD_BITS;
    localparam int QB = mhd_pkg::QUO_BITS;
    localparam int NL = mhd_pkg::NUM_LANES;

    mhd_pkg::word_t gamma_w;
    mhd_pkg::word_t inv_gamma_w;

    assign gamma_w     = {{(W-mhd_pkg::GM_BITS){1'b0}}, gamma_minus_one};
    assign inv_gamma_w = {{(W-mhd_pkg::IGM_BITS){1'b0}}, inv_gamma_minus_one};

    // Stage 0: signed and saturated quotients, or velocities taken as given.
    logic              a0_vld_reg, a0_vld_next;
    mhd_pkg::in_word_t a0_pay_reg;
    mhd_pkg::word_t    a0_v_reg [NL];
    mhd_pkg::word_t    a0_v_next [NL];
    logic              a0_clip_reg, a0_clip_next;

    always_comb
    begin
        logic [QB-1:0]  q;
        logic           neg;
        logic           clp;
        mhd_pkg::word_t dv;
        a0_vld_next  = in_valid;
        a0_clip_next = 1'b0;
        for (int l = 0; l < NL; l++)
        begin
            q   = quo[l];
            neg = mhd_pkg::comp_of(in_word, l) >= 0 ? 1'b0 : 1'b1;
            if (!neg)
            begin
                clp = (q[QB-1:W-1] != '0);
                dv  = clp ? mhd_pkg::WMAX : q[W-1:0];
            end
            else
            begin
                clp = (q[QB-1:W] != '0) || (q[W-1] && (q[W-2:0] != '0));
                dv  = clp ? mhd_pkg::WMIN : (~q[W-1:0] + W'(1));
            end
            if (in_word.operation == mhd_pkg::OP_CONS_TO_PRIM)
            begin
                a0_v_next[l] = dv;
                a0_clip_next = a0_clip_next | clp;
            end
            else
            begin
                a0_v_next[l] = mhd_pkg::comp_of(in_word, l);
            end
        end
    end

    // Stage 1: squares of the velocities and fields, density times each component, pressure term.
    logic              a1_vld_reg;
    mhd_pkg::in_word_t a1_pay_reg;
    mhd_pkg::word_t    a1_v_reg   [NL];
    mhd_pkg::word_t    a1_sqv_reg [NL];
    mhd_pkg::word_t    a1_mom_reg [NL];
    mhd_pkg::word_t    a1_sqb_reg [NL];
    mhd_pkg::word_t    a1_pe_reg;
    logic              a1_clip_reg;
    mhd_pkg::qres_t    a1_sqv_next [NL];
    mhd_pkg::qres_t    a1_mom_next [NL];
    mhd_pkg::qres_t    a1_sqb_next [NL];
    mhd_pkg::qres_t    a1_pe_next;
    logic              a1_clip_next;

    always_comb
    begin
        logic p2c;
        p2c          = (a0_pay_reg.operation == mhd_pkg::OP_PRIM_TO_CONS);
        a1_pe_next   = mhd_pkg::qmul(a0_pay_reg.in_energy_or_pressure, inv_gamma_w);
        a1_clip_next = a0_clip_reg | (p2c & a1_pe_next.clip);
        for (int l = 0; l < NL; l++)
        begin
            a1_sqv_next[l] = mhd_pkg::qmul(a0_v_reg[l], a0_v_reg[l]);
            a1_mom_next[l] = mhd_pkg::qmul(a0_pay_reg.in_density,
                                           mhd_pkg::comp_of(a0_pay_reg, l));
            a1_sqb_next[l] = mhd_pkg::qmul(mhd_pkg::field_of(a0_pay_reg, l),
                                           mhd_pkg::field_of(a0_pay_reg, l));
            a1_clip_next   = a1_clip_next | a1_sqv_next[l].clip | a1_sqb_next[l].clip
                           | (p2c & a1_mom_next[l].clip);
        end
    end

    // Stage 2: sums of squares.
    logic              a2_vld_reg;
    mhd_pkg::in_word_t a2_pay_reg;
    mhd_pkg::word_t    a2_v_reg   [NL];
    mhd_pkg::word_t    a2_mom_reg [NL];
    mhd_pkg::word_t    a2_pe_reg;
    mhd_pkg::word_t    a2_sq_reg;
    mhd_pkg::word_t    a2_bs_reg;
    logic              a2_clip_reg;
    mhd_pkg::qres_t    a2_sq_next, a2_bs_next;
    logic              a2_clip_next;

    always_comb
    begin
        mhd_pkg::qres_t s;
        mhd_pkg::qres_t t;
        s          = mhd_pkg::qadd(a1_sqv_reg[0], a1_sqv_reg[1]);
        a2_sq_next = mhd_pkg::qadd(s.val, a1_sqv_reg[2]);
        t          = mhd_pkg::qadd(a1_sqb_reg[0], a1_sqb_reg[1]);
        a2_bs_next = mhd_pkg::qadd(t.val, a1_sqb_reg[2]);
        a2_clip_next = a1_clip_reg | s.clip | a2_sq_next.clip | t.clip | a2_bs_next.clip;
    end

    // Stage 3: density times squared speed, half of B squared.
    logic              a3_vld_reg;
    mhd_pkg::in_word_t a3_pay_reg;
    mhd_pkg::word_t    a3_v_reg   [NL];
    mhd_pkg::word_t    a3_mom_reg [NL];
    mhd_pkg::word_t    a3_pe_reg;
    mhd_pkg::word_t    a3_rk_reg;
    mhd_pkg::word_t    a3_bh_reg;
    logic              a3_clip_reg;
    mhd_pkg::qres_t    a3_rk_next;

    assign a3_rk_next = mhd_pkg::qmul(a2_pay_reg.in_density, a2_sq_reg);

    // Stage 4: kinetic energy and the energy balance.
    logic              a4_vld_reg;
    mhd_pkg::in_word_t a4_pay_reg;
    mhd_pkg::word_t    a4_v_reg   [NL];
    mhd_pkg::word_t    a4_mom_reg [NL];
    mhd_pkg::word_t    a4_oe_reg;
    logic              a4_clip_reg;
    mhd_pkg::qres_t    a4_oe_next;
    logic              a4_clip_next;

    always_comb
    begin
        mhd_pkg::word_t ke;
        mhd_pkg::qres_t t;
        ke = mhd_pkg::qhalf(a3_rk_reg);
        if (a3_pay_reg.operation == mhd_pkg::OP_CONS_TO_PRIM)
        begin
            t          = mhd_pkg::qsub(a3_pay_reg.in_energy_or_pressure, ke);
            a4_oe_next = mhd_pkg::qsub(t.val, a3_bh_reg);
        end
        else
        begin
            t          = mhd_pkg::qadd(ke, a3_pe_reg);
            a4_oe_next = mhd_pkg::qadd(t.val, a3_bh_reg);
        end
        a4_clip_next = a3_clip_reg | t.clip | a4_oe_next.clip;
    end

    // Stage 5: pressure scaling, zeroing and status.
    logic               a5_vld_reg;
    mhd_pkg::out_word_t a5_res_reg;
    mhd_pkg::out_word_t a5_res_next;

    always_comb
    begin
        mhd_pkg::qres_t pr;
        mhd_pkg::word_t oe;
        logic           clip;
        logic           rho_bad;
        logic           c2p;
        rho_bad = (a4_pay_reg.in_density <= 0);
        c2p     = (a4_pay_reg.operation == mhd_pkg::OP_CONS_TO_PRIM);
        pr      = mhd_pkg::qmul(a4_oe_reg, gamma_w);
        clip    = a4_clip_reg;
        a5_res_next.out_density = a4_pay_reg.in_density;
        a5_res_next.out_field_x = a4_pay_reg.in_field_x;
        a5_res_next.out_field_y = a4_pay_reg.in_field_y;
        a5_res_next.out_field_z = a4_pay_reg.in_field_z;
        if (c2p)
        begin
            oe   = pr.val;
            clip = clip | pr.clip;
            a5_res_next.out_x_comp = a4_v_reg[0];
            a5_res_next.out_y_comp = a4_v_reg[1];
            a5_res_next.out_z_comp = a4_v_reg[2];
            if (rho_bad)
            begin
                oe = '0;
                a5_res_next.out_x_comp = '0;
                a5_res_next.out_y_comp = '0;
                a5_res_next.out_z_comp = '0;
            end
        end
        else
        begin
            oe = a4_oe_reg;
            a5_res_next.out_x_comp = a4_mom_reg[0];
            a5_res_next.out_y_comp = a4_mom_reg[1];
            a5_res_next.out_z_comp = a4_mom_reg[2];
        end
        a5_res_next.out_energy_or_pressure = oe;
        if (rho_bad)
            a5_res_next.status = mhd_pkg::STATUS_DENSITY;
        else if (clip)
            a5_res_next.status = mhd_pkg::STATUS_SAT;
        else if (oe <= 0)
            a5_res_next.status = mhd_pkg::STATUS_NONPOS;
        else
            a5_res_next.status = mhd_pkg::STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0_vld_reg <= 1'b0;
            a1_vld_reg <= 1'b0;
            a2_vld_reg <= 1'b0;
            a3_vld_reg <= 1'b0;
            a4_vld_reg <= 1'b0;
            a5_vld_reg <= 1'b0;
        end
        else
        begin
            a0_vld_reg <= a0_vld_next;
            a1_vld_reg <= a0_vld_reg;
            a2_vld_reg <= a1_vld_reg;
            a3_vld_reg <= a2_vld_reg;
            a4_vld_reg <= a3_vld_reg;
            a5_vld_reg <= a4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a0_pay_reg  <= in_word;
        a0_clip_reg <= a0_clip_next;
        a1_pay_reg  <= a0_pay_reg;
        a1_pe_reg   <= a1_pe_next.val;
        a1_clip_reg <= a1_clip_next;
        a2_pay_reg  <= a1_pay_reg;
        a2_pe_reg   <= a1_pe_reg;
        a2_sq_reg   <= a2_sq_next.val;
        a2_bs_reg   <= a2_bs_next.val;
        a2_clip_reg <= a2_clip_next;
        a3_pay_reg  <= a2_pay_reg;
        a3_pe_reg   <= a2_pe_reg;
        a3_rk_reg   <= a3_rk_next.val;
        a3_bh_reg   <= mhd_pkg::qhalf(a2_bs_reg);
        a3_clip_reg <= a2_clip_reg | a3_rk_next.clip;
        a4_pay_reg  <= a3_pay_reg;
        a4_oe_reg   <= a4_oe_next.val;
        a4_clip_reg <= a4_clip_next;
        a5_res_reg  <= a5_res_next;
        for (int l = 0; l < NL; l++)
        begin
            a0_v_reg[l]   <= a0_v_next[l];
            a1_v_reg[l]   <= a0_v_reg[l];
            a1_sqv_reg[l] <= a1_sqv_next[l].val;
            a1_mom_reg[l] <= a1_mom_next[l].val;
            a1_sqb_reg[l] <= a1_sqb_next[l].val;
            a2_v_reg[l]   <= a1_v_reg[l];
            a2_mom_reg[l] <= a1_mom_reg[l];
            a3_v_reg[l]   <= a2_v_reg[l];
            a3_mom_reg[l] <= a2_mom_reg[l];
            a4_v_reg[l]   <= a3_v_reg[l];
            a4_mom_reg[l] <= a3_mom_reg[l];
        end
    end

    assign out_valid = a5_vld_reg;
    assign out_word  = a5_res_reg;

endmodule

/* src/mhd_state_converter.sv */
// Ideal-MHD cell state converter, conserved to primitive form and back.
// Input channel: a word is taken at every rising edge with start high and
// busy low. busy is always low, so a new word may enter in every cycle and
// the block sustains one state per clock.
// Each word carries the operation (0 conserved to primitive, 1 primitive to
// conserved) and eight signed Q16.16 values. Density and the magnetic field
// pass through unchanged.
// Result channel: done is high for exactly one cycle with the result word
// and its status code. Results leave in the order the words entered,
// after 48 stages of the bit-serial momentum divider
// (one quotient bit per stage, three lanes side by side) followed by six
// arithmetic stages with at most one multiply level each. Primitive to
// conserved words take the same path so the order is kept.
// The receiver cannot hold results off, and no flow control is needed.
// Configuration: an APB-style port holds gamma minus one at address 0 and
// its reciprocal at address 4; write them only while no word is in flight.
// Reset clears every valid bit in the pipeline and loads gamma five thirds;
// no result appears until a new word is accepted.
module mhd_state_converter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  mhd_pkg::in_word_t              item,
    output logic                           done,
    output mhd_pkg::out_word_t             result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mhd_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [mhd_pkg::DATA_BITS-1:0]  pwdata,
    output logic [mhd_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready
);

    logic [mhd_pkg::GM_BITS-1:0]  gamma_minus_one;
    logic [mhd_pkg::IGM_BITS-1:0] inv_gamma_minus_one;
    logic                         div_valid;
    mhd_pkg::in_word_t            div_word;
    mhd_pkg::quo_vec_t            div_quo;

    // The pipeline never stalls, so the block is always ready.
    assign busy = 1'b0;

    mhd_cfg u_cfg (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .gamma_minus_one     (gamma_minus_one),
        .inv_gamma_minus_one (inv_gamma_minus_one)
    );

    // Momentum over density for all three components.
    mhd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .in_word   (item),
        .out_valid (div_valid),
        .out_word  (div_word),
        .quo       (div_quo)
    );

    // Products, sums, energy balance, saturation and status.
    mhd_arith u_arith (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (div_valid),
        .in_word             (div_word),
        .quo                 (div_quo),
        .gamma_minus_one     (gamma_minus_one),
        .inv_gamma_minus_one (inv_gamma_minus_one),
        .out_valid           (done),
        .out_word            (result)
    );

endmodule

/* bench/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Pipeline depth of the block, from the description at its head:
    // 48 divider stages and six arithmetic stages.
    localparam int PIPE_CYCLES = 54;
    localparam int NUM_RANDOM  = 1200;

    // Scoreboard: it holds the configuration that the block was given, works
    // out the result word for every accepted input word, and compares the
    // result words with the oldest expectation in the queue.
    class mhd_scoreboard;
        logic [mhd_pkg::GM_BITS-1:0]  gm;
        logic [mhd_pkg::IGM_BITS-1:0] igm;
        mhd_pkg::out_word_t           pending[$];
        int                           mismatches;
        bit                           clip;

        function new();
            gm = mhd_pkg::GM_RESET;
            igm = mhd_pkg::IGM_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(logic idx, logic [mhd_pkg::DATA_BITS-1:0] v);
            if (idx == mhd_pkg::REG_GAMMA)
                gm = v[mhd_pkg::GM_BITS-1:0];
            else
                igm = v[mhd_pkg::IGM_BITS-1:0];
        endfunction

        function longint clamp(longint x);
            if (x > 64'sd2147483647)
            begin
                clip = 1;
                return 64'sd2147483647;
            end
            if (x < -64'sd2147483648)
            begin
                clip = 1;
                return -64'sd2147483648;
            end
            return x;
        endfunction

        // Rounds half up: the arithmetic shift floors.
        function longint fmul(longint a, longint b);
            longint p;
            p = a * b + (64'sd1 <<< (mhd_pkg::FRAC_BITS - 1));
            return clamp(p >>> mhd_pkg::FRAC_BITS);
        endfunction

        function longint fadd(longint a, longint b);
            return clamp(a + b);
        endfunction

        function longint squares(longint a, longint b, longint c);
            return fadd(fadd(fmul(a, a), fmul(b, b)), fmul(c, c));
        endfunction

        // Quotient truncated toward zero, which SystemVerilog division does.
        function longint fdiv(longint m, longint rho);
            return clamp((m <<< mhd_pkg::FRAC_BITS) / rho);
        endfunction

        function void note_input(mhd_pkg::in_word_t w);
            mhd_pkg::out_word_t r;
            longint rho, x, y, z, ep, ox, oy, oz, oe, bh, ke, half;
            clip = 0;
            half = 64'sd1 <<< (mhd_pkg::FRAC_BITS - 1);
            rho = w.in_density;
            x = w.in_x_comp;
            y = w.in_y_comp;
            z = w.in_z_comp;
            ep = w.in_energy_or_pressure;
            ox = 0;
            oy = 0;
            oz = 0;
            oe = 0;
            bh = fmul(half, squares(w.in_field_x, w.in_field_y, w.in_field_z));
            if (w.operation == mhd_pkg::OP_CONS_TO_PRIM)
            begin
                // A density that is not positive skips the division entirely.
                if (rho > 0)
                begin
                    ox = fdiv(x, rho);
                    oy = fdiv(y, rho);
                    oz = fdiv(z, rho);
                    ke = fmul(half, fmul(rho, squares(ox, oy, oz)));
                    oe = fadd(fadd(ep, -ke), -bh);
                    oe = fmul(oe, longint'(gm));
                end
            end
            else
            begin
                ox = fmul(rho, x);
                oy = fmul(rho, y);
                oz = fmul(rho, z);
                ke = fmul(half, fmul(rho, squares(x, y, z)));
                oe = fadd(ke, fmul(ep, longint'(igm)));
                oe = fadd(oe, bh);
            end
            r.out_density = w.in_density;
            r.out_x_comp = mhd_pkg::word_t'(ox);
            r.out_y_comp = mhd_pkg::word_t'(oy);
            r.out_z_comp = mhd_pkg::word_t'(oz);
            r.out_energy_or_pressure = mhd_pkg::word_t'(oe);
            r.out_field_x = w.in_field_x;
            r.out_field_y = w.in_field_y;
            r.out_field_z = w.in_field_z;
            if (rho <= 0)
                r.status = mhd_pkg::STATUS_DENSITY;
            else if (clip)
                r.status = mhd_pkg::STATUS_SAT;
            else if (oe <= 0)
                r.status = mhd_pkg::STATUS_NONPOS;
            else
                r.status = mhd_pkg::STATUS_OK;
            pending.push_back(r);
        endfunction

        function void check_result(mhd_pkg::out_word_t got);
            mhd_pkg::out_word_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.out_density !== want.out_density
                || got.out_x_comp !== want.out_x_comp
                || got.out_y_comp !== want.out_y_comp
                || got.out_z_comp !== want.out_z_comp
                || got.out_energy_or_pressure !== want.out_energy_or_pressure
                || got.out_field_x !== want.out_field_x
                || got.out_field_y !== want.out_field_y
                || got.out_field_z !== want.out_field_z
                || got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    mhd_pkg::in_word_t             item;
    logic                          done;
    mhd_pkg::out_word_t            result;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [mhd_pkg::ADDR_BITS-1:0] paddr;
    logic [mhd_pkg::DATA_BITS-1:0] pwdata;
    logic [mhd_pkg::DATA_BITS-1:0] prdata;
    logic                          pready;

    mhd_scoreboard conv_board;
    bit            idle_allowed;

    mhd_state_converter i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result words are taken at the edge that ends their cycle. The sample is
    // made on the old values, so the order of events at that edge does not
    // matter.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            conv_board.check_result(result);
    end

    // Hard limit: the 1215 words with their gaps, plus the drains,
    // fit well inside 200 us.
    initial
    begin
        #200000;
        $display("TB_ERROR");
        $finish;
    end

    // Writes one register through the setup and access cycles.
    task automatic write_reg(logic idx, logic [mhd_pkg::DATA_BITS-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mhd_pkg::ADDR_BITS'(idx) << mhd_pkg::IDX_BIT;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        conv_board.set_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Presents one word and holds it until the block takes it. The valid is
    // only lowered on a gap, so it never drops and rises in one step.
    task automatic send_word(mhd_pkg::in_word_t w);
        int gap;
        if (idle_allowed && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        conv_board.note_input(w);
    endtask

    // Waits until all expected words have come and the pipeline has drained.
    task automatic drain();
        int guard;
        start <= 1'b0;
        guard = 0;
        while (conv_board.pending.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (PIPE_CYCLES + 4) @(posedge clk);
    endtask

    function automatic mhd_pkg::word_t rand_word();
        case ($urandom_range(0, 5))
            0: return mhd_pkg::WMAX;
            1: return mhd_pkg::WMIN;
            2: return mhd_pkg::word_t'($urandom_range(0, 32'h0004_0000));
            3: return -mhd_pkg::word_t'($urandom_range(0, 32'h0004_0000));
            default: return mhd_pkg::word_t'($urandom);
        endcase
    endfunction

    // Physically sensible states get past the early checks: positive density
    // and modest speeds and fields. The rest of the words are raw noise.
    function automatic mhd_pkg::in_word_t rand_state();
        mhd_pkg::in_word_t w;
        w.operation = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0)
        begin
            w.in_density = mhd_pkg::word_t'($urandom_range(32'h0000_1000, 32'h0008_0000));
            w.in_x_comp = mhd_pkg::word_t'($urandom_range(0, 32'h0006_0000))
                - 32'sh0003_0000;
            w.in_y_comp = mhd_pkg::word_t'($urandom_range(0, 32'h0006_0000))
                - 32'sh0003_0000;
            w.in_z_comp = mhd_pkg::word_t'($urandom_range(0, 32'h0006_0000))
                - 32'sh0003_0000;
            w.in_energy_or_pressure = mhd_pkg::word_t'($urandom_range(0, 32'h0040_0000))
                - 32'sh0002_0000;
            w.in_field_x = mhd_pkg::word_t'($urandom_range(0, 32'h0004_0000))
                - 32'sh0002_0000;
            w.in_field_y = mhd_pkg::word_t'($urandom_range(0, 32'h0004_0000))
                - 32'sh0002_0000;
            w.in_field_z = mhd_pkg::word_t'($urandom_range(0, 32'h0004_0000))
                - 32'sh0002_0000;
        end
        else
        begin
            w.in_density = rand_word();
            w.in_x_comp = rand_word();
            w.in_y_comp = rand_word();
            w.in_z_comp = rand_word();
            w.in_energy_or_pressure = rand_word();
            w.in_field_x = rand_word();
            w.in_field_y = rand_word();
            w.in_field_z = rand_word();
        end
        return w;
    endfunction

    function automatic mhd_pkg::in_word_t make_state(logic op, mhd_pkg::word_t rho,
                                                     mhd_pkg::word_t m, mhd_pkg::word_t e,
                                                     mhd_pkg::word_t b);
        mhd_pkg::in_word_t w;
        w.operation = op;
        w.in_density = rho;
        w.in_x_comp = m;
        w.in_y_comp = -m;
        w.in_z_comp = m >>> 1;
        w.in_energy_or_pressure = e;
        w.in_field_x = b;
        w.in_field_y = -b;
        w.in_field_z = b >>> 2;
        return w;
    endfunction

    initial
    begin
        logic [mhd_pkg::DATA_BITS-1:0] gm_set[4];
        logic [mhd_pkg::DATA_BITS-1:0] igm_set[4];
        int                            n;
        conv_board = new();
        idle_allowed = 1'b1;
        rst_n   = 1'b0;
        start   = 1'b0;
        item    = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset configuration: an ordinary state in
        // both directions, zero and negative density, a result of zero or
        // below, saturation, and the extremes of every field.
        send_word(make_state(mhd_pkg::OP_CONS_TO_PRIM, 32'sh0001_0000, 32'sh0002_0000,
                             32'sh000A_0000, 32'sh0000_8000));
        send_word(make_state(mhd_pkg::OP_PRIM_TO_CONS, 32'sh0001_0000, 32'sh0002_0000,
                             32'sh000A_0000, 32'sh0000_8000));
        send_word(make_state(mhd_pkg::OP_CONS_TO_PRIM, 32'sh0, 32'sh0002_0000,
                             32'sh000A_0000, 32'sh0000_8000));
        send_word(make_state(mhd_pkg::OP_PRIM_TO_CONS, 32'sh0, 32'sh0002_0000,
                             32'sh000A_0000, 32'sh0000_8000));
        send_word(make_state(mhd_pkg::OP_CONS_TO_PRIM, mhd_pkg::WMIN, mhd_pkg::WMAX,
                             mhd_pkg::WMAX, mhd_pkg::WMIN));
        send_word(make_state(mhd_pkg::OP_PRIM_TO_CONS, -32'sh0001_0000, mhd_pkg::WMIN,
                             mhd_pkg::WMIN, mhd_pkg::WMAX));
        send_word(make_state(mhd_pkg::OP_CONS_TO_PRIM, 32'sh0001_0000, 32'sh0001_0000,
                             32'sh0, 32'sh0));
        send_word(make_state(mhd_pkg::OP_PRIM_TO_CONS, 32'sh0001_0000, 32'sh0,
                             -32'sh0001_0000, 32'sh0));
        send_word(make_state(mhd_pkg::OP_CONS_TO_PRIM, 32'sh1, mhd_pkg::WMAX,
                             mhd_pkg::WMAX, 32'sh0));
        send_word(make_state(mhd_pkg::OP_PRIM_TO_CONS, mhd_pkg::WMAX, mhd_pkg::WMAX,
                             mhd_pkg::WMAX, mhd_pkg::WMAX));
        send_word(make_state(mhd_pkg::OP_CONS_TO_PRIM, mhd_pkg::WMAX, mhd_pkg::WMIN,
                             mhd_pkg::WMIN, mhd_pkg::WMIN));
        send_word(make_state(mhd_pkg::OP_PRIM_TO_CONS, 32'sh1, mhd_pkg::WMIN,
                             32'sh1, 32'sh1));
        send_word(make_state(mhd_pkg::OP_CONS_TO_PRIM, 32'sh0001_0000, 32'sh0,
                             32'sh0, 32'sh0));
        send_word('1);
        send_word('0);
        drain();

        // Four settings: each register zero once with the other at a power of two,
        // then the reset pair and a random pair. Each phase streams random states.
        gm_set  = '{32'd0, 32'd1048576, 32'd43691, 32'($urandom_range(0, 1048576))};
        igm_set = '{32'd16777216, 32'd0, 32'd98304, 32'($urandom_range(0, 16777216))};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(mhd_pkg::REG_GAMMA, gm_set[ph]);
            write_reg(mhd_pkg::REG_INV_GAMMA, igm_set[ph]);
            // Register writes keep only the low bits of the data word.
            if (ph == 3)
                write_reg(mhd_pkg::REG_GAMMA, $urandom | 32'hFFE0_0000);
            // The final stretch of the run streams words with no gaps.
            idle_allowed = (ph != 3);
            n = NUM_RANDOM / 4;
            repeat (n) send_word(rand_state());
            drain();
        end

        if (conv_board.mismatches == 0 && conv_board.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* filelist.f */
src/mhd_pkg.sv
src/mhd_cfg.sv
src/mhd_div.sv
src/mhd_arith.sv
src/mhd_state_converter.sv
bench/tb.sv
